// ===== sv/bfha_pkg.sv =====
// bfha_pkg: shared types and constants for the best-fit heap allocator
// holds the controller command set, the status codes and the header flag masks
// used by bfha_ctrl, bfha_dpath and the top level; depends on nothing
package bfha_pkg;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_BAD_OFF  = 3'd3;
  localparam logic [2:0] ST_ALR_FREE = 3'd4;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // header word masks
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] NOT_P     = 32'hFFFF_FFFD;
  localparam logic [31:0] NOT_A     = 32'hFFFF_FFFE;
  localparam logic [31:0] A_FLAG    = 32'h0000_0001;
  localparam logic [31:0] P_FLAG    = 32'h0000_0002;
  localparam logic [31:0] FIRST     = 32'd4;
  localparam logic [31:0] MIN_SPLIT = 32'd8;

  // datapath micro-operations
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_LOAD,
    CMD_A_RD,
    CMD_A_EV,
    CMD_X_RD,
    CMD_X_WR,
    CMD_S_W1,
    CMD_S_W2,
    CMD_S_RD,
    CMD_S_W3,
    CMD_A_OK,
    CMD_FX_RD,
    CMD_FX_EV,
    CMD_FX_RN,
    CMD_FX_WN,
    CMD_F_RD,
    CMD_F_H,
    CMD_F_PRD,
    CMD_F_PV,
    CMD_F_NRD,
    CMD_F_NV,
    CMD_F_PRV_RD,
    CMD_F_PRV_WR,
    CMD_F_NS,
    CMD_F_BRD,
    CMD_F_BADD,
    CMD_F_CLRA,
    CMD_F_FOOT,
    CMD_F_OK,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic req_zero;
    logic too_big;
    logic bad_off;
    logic scan_go;
    logic scan_stop;
    logic best_zero;
    logic exact;
    logic fx_go;
    logic h_a;
    logic h_p;
    logic nx_in;
    logic has_prev;
    logic has_next;
  } dp_sts_t;

endpackage

// ===== sv/bfha_ctrl.sv =====
// bfha_ctrl: sequencer for allocate, free and the post-reset clearing pass
// issues one bfha_pkg::ctl_cmd_t a cycle to bfha_dpath, reads bfha_pkg::dp_sts_t
// depends on bfha_pkg
module bfha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bfha_pkg::dp_sts_t  sts_i,
  output bfha_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [36:0] {
    S_CLEAR    = 37'b1 << 0,
    S_IDLE     = 37'b1 << 1,
    S_DISP     = 37'b1 << 2,
    S_A_RD     = 37'b1 << 3,
    S_A_EV     = 37'b1 << 4,
    S_A_DEC    = 37'b1 << 5,
    S_X_RD     = 37'b1 << 6,
    S_X_WR     = 37'b1 << 7,
    S_S_W1     = 37'b1 << 8,
    S_S_W2     = 37'b1 << 9,
    S_S_RD     = 37'b1 << 10,
    S_S_W3     = 37'b1 << 11,
    S_A_OK     = 37'b1 << 12,
    S_FX_RD    = 37'b1 << 13,
    S_FX_EV    = 37'b1 << 14,
    S_FX_RN    = 37'b1 << 15,
    S_FX_WN    = 37'b1 << 16,
    S_F_RD     = 37'b1 << 17,
    S_F_H      = 37'b1 << 18,
    S_F_PRD    = 37'b1 << 19,
    S_F_PV     = 37'b1 << 20,
    S_F_NCHK   = 37'b1 << 21,
    S_F_NRD    = 37'b1 << 22,
    S_F_NV     = 37'b1 << 23,
    S_F_MRG    = 37'b1 << 24,
    S_F_PRV_RD = 37'b1 << 25,
    S_F_PRV_WR = 37'b1 << 26,
    S_F_NRD2   = 37'b1 << 27,
    S_F_NS     = 37'b1 << 28,
    S_F_BRD1   = 37'b1 << 29,
    S_F_BADD   = 37'b1 << 30,
    S_F_BRD2   = 37'b1 << 31,
    S_F_CLRA   = 37'b1 << 32,
    S_F_FOOT   = 37'b1 << 33,
    S_F_OK     = 37'b1 << 34,
    S_FIN      = 37'b1 << 35,
    S_OUT      = 37'b1 << 36
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;

  // state and pending error code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= bfha_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // next state and command
  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    cmd_o.cmd  = bfha_pkg::CMD_NONE;
    cmd_o.code = code_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.cmd = bfha_pkg::CMD_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = bfha_pkg::CMD_LOAD;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_free) begin
          if (sts_i.bad_off) begin
            code_d  = bfha_pkg::ST_BAD_OFF;
            state_d = S_FIN;
          end else begin
            state_d = S_F_RD;
          end
        end else if (sts_i.req_zero) begin
          code_d  = bfha_pkg::ST_BAD_SIZE;
          state_d = S_FIN;
        end else if (sts_i.too_big) begin
          code_d  = bfha_pkg::ST_NO_FIT;
          state_d = S_FIN;
        end else begin
          state_d = S_A_RD;
        end
      end
      // block walk
      S_A_RD: begin
        if (sts_i.scan_go) begin
          cmd_o.cmd = bfha_pkg::CMD_A_RD;
          state_d   = S_A_EV;
        end else begin
          state_d = S_A_DEC;
        end
      end
      S_A_EV: begin
        cmd_o.cmd = bfha_pkg::CMD_A_EV;
        state_d   = sts_i.scan_stop ? S_A_DEC : S_A_RD;
      end
      S_A_DEC: begin
        if (sts_i.best_zero) begin
          code_d  = bfha_pkg::ST_NO_FIT;
          state_d = S_FIN;
        end else begin
          state_d = sts_i.exact ? S_X_RD : S_S_W1;
        end
      end
      // exact fit
      S_X_RD: begin
        cmd_o.cmd = bfha_pkg::CMD_X_RD;
        state_d   = S_X_WR;
      end
      S_X_WR: begin
        cmd_o.cmd = bfha_pkg::CMD_X_WR;
        state_d   = S_FX_RD;
      end
      // split
      S_S_W1: begin
        cmd_o.cmd = bfha_pkg::CMD_S_W1;
        state_d   = S_S_W2;
      end
      S_S_W2: begin
        cmd_o.cmd = bfha_pkg::CMD_S_W2;
        state_d   = S_S_RD;
      end
      S_S_RD: begin
        cmd_o.cmd = bfha_pkg::CMD_S_RD;
        state_d   = S_S_W3;
      end
      S_S_W3: begin
        cmd_o.cmd = bfha_pkg::CMD_S_W3;
        state_d   = S_A_OK;
      end
      S_A_OK: begin
        cmd_o.cmd = bfha_pkg::CMD_A_OK;
        state_d   = S_OUT;
      end
      // next block's previous-allocated bit
      S_FX_RD: begin
        cmd_o.cmd = bfha_pkg::CMD_FX_RD;
        state_d   = S_FX_EV;
      end
      S_FX_EV: begin
        cmd_o.cmd = bfha_pkg::CMD_FX_EV;
        if (sts_i.fx_go) state_d = S_FX_RN;
        else             state_d = sts_i.is_free ? S_F_OK : S_A_OK;
      end
      S_FX_RN: begin
        cmd_o.cmd = bfha_pkg::CMD_FX_RN;
        state_d   = S_FX_WN;
      end
      S_FX_WN: begin
        cmd_o.cmd = bfha_pkg::CMD_FX_WN;
        state_d   = sts_i.is_free ? S_F_OK : S_A_OK;
      end
      // free
      S_F_RD: begin
        cmd_o.cmd = bfha_pkg::CMD_F_RD;
        state_d   = S_F_H;
      end
      S_F_H: begin
        cmd_o.cmd = bfha_pkg::CMD_F_H;
        if (!sts_i.h_a) begin
          code_d  = bfha_pkg::ST_ALR_FREE;
          state_d = S_FIN;
        end else begin
          state_d = sts_i.h_p ? S_F_NCHK : S_F_PRD;
        end
      end
      S_F_PRD: begin
        cmd_o.cmd = bfha_pkg::CMD_F_PRD;
        state_d   = S_F_PV;
      end
      S_F_PV: begin
        cmd_o.cmd = bfha_pkg::CMD_F_PV;
        state_d   = S_F_NCHK;
      end
      S_F_NCHK: begin
        state_d = sts_i.nx_in ? S_F_NRD : S_F_MRG;
      end
      S_F_NRD: begin
        cmd_o.cmd = bfha_pkg::CMD_F_NRD;
        state_d   = S_F_NV;
      end
      S_F_NV: begin
        cmd_o.cmd = bfha_pkg::CMD_F_NV;
        state_d   = S_F_MRG;
      end
      S_F_MRG: begin
        if (sts_i.has_prev)      state_d = S_F_PRV_RD;
        else if (sts_i.has_next) state_d = S_F_NRD2;
        else                     state_d = S_F_BRD2;
      end
      S_F_PRV_RD: begin
        cmd_o.cmd = bfha_pkg::CMD_F_PRV_RD;
        state_d   = S_F_PRV_WR;
      end
      S_F_PRV_WR: begin
        cmd_o.cmd = bfha_pkg::CMD_F_PRV_WR;
        state_d   = sts_i.has_next ? S_F_NRD2 : S_F_BRD2;
      end
      S_F_NRD2: begin
        cmd_o.cmd = bfha_pkg::CMD_F_NRD;
        state_d   = S_F_NS;
      end
      S_F_NS: begin
        cmd_o.cmd = bfha_pkg::CMD_F_NS;
        state_d   = S_F_BRD1;
      end
      S_F_BRD1: begin
        cmd_o.cmd = bfha_pkg::CMD_F_BRD;
        state_d   = S_F_BADD;
      end
      S_F_BADD: begin
        cmd_o.cmd = bfha_pkg::CMD_F_BADD;
        state_d   = S_F_BRD2;
      end
      S_F_BRD2: begin
        cmd_o.cmd = bfha_pkg::CMD_F_BRD;
        state_d   = S_F_CLRA;
      end
      S_F_CLRA: begin
        cmd_o.cmd = bfha_pkg::CMD_F_CLRA;
        state_d   = S_F_FOOT;
      end
      S_F_FOOT: begin
        cmd_o.cmd = bfha_pkg::CMD_F_FOOT;
        state_d   = S_FX_RD;
      end
      S_F_OK: begin
        cmd_o.cmd = bfha_pkg::CMD_F_OK;
        state_d   = S_OUT;
      end
      S_FIN: begin
        cmd_o.cmd = bfha_pkg::CMD_FIN;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bfha_dpath.sv =====
// bfha_dpath: heap word memory, walk registers and result registers
// executes one bfha_pkg::cmd_e per cycle; one write and one registered read port
// depends on bfha_pkg
module bfha_dpath #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfha_pkg::ctl_cmd_t cmd_i,
  input  logic               opcode_i,
  input  logic [15:0]        request_bytes_i,
  input  logic [15:0]        payload_offset_i,
  output bfha_pkg::dp_sts_t  sts_o,
  output logic [2:0]         status_o,
  output logic [15:0]        result_offset_o
);

  localparam int          WORDS  = HEAP_BYTES / 4;
  localparam int          IW     = $clog2(WORDS);
  localparam logic [31:0] REGION = (32'(HEAP_BYTES) & 32'hFFFF_FFF8) - 32'd8;
  localparam logic [31:0] LIMIT  = bfha_pkg::FIRST + REGION;
  localparam logic [31:0] NMAX32 = REGION >> 2;
  localparam int          NW     = $clog2(REGION / 4 + 2);
  localparam logic [NW-1:0] NMAX = NMAX32[NW-1:0];
  localparam logic [IW-1:0] IDX_HDR  = IW'(1);
  localparam logic [IW-1:0] IDX_FOOT = IW'((LIMIT - 32'd4) >> 2);
  localparam logic [IW-1:0] IDX_END  = IW'(LIMIT >> 2);
  localparam logic [IW-1:0] IDX_LAST = IW'(WORDS - 1);

  logic [31:0] mem_q [WORDS];
  logic [31:0] rdata_q;
  logic        rd_ok_q;

  logic          op_q;
  logic [15:0]   poff_q;
  logic [15:0]   used_q;
  logic [IW-1:0] clr_q;
  logic [NW-1:0] n_q;
  logic [31:0]   need_q, pcur_q, cur_q, best_q, bs_q, h_q, freed_q;
  logic [31:0]   prev_q, nx_q, nxs_q, blk_q;
  logic          has_prev_q, has_next_q;
  logic [2:0]    st_q;
  logic [15:0]   off_q;
  logic          req_zero_q;

  logic [31:0] rd_val, size_rd, raddr, waddr, wdata, init_w, rem, f_diff;
  logic        re, we;

  assign rd_val  = rd_ok_q ? rdata_q : '0;
  assign size_rd = rd_val & bfha_pkg::SIZE_MASK;
  assign rem     = ({16'd0, used_q} < REGION) ? REGION - {16'd0, used_q} : '0;
  assign f_diff  = pcur_q - rd_val;

  // reset image of the heap
  always_comb begin
    if (clr_q == IDX_HDR)       init_w = REGION | bfha_pkg::P_FLAG;
    else if (clr_q == IDX_FOOT) init_w = REGION;
    else if (clr_q == IDX_END)  init_w = bfha_pkg::A_FLAG;
    else                        init_w = '0;
  end

  // memory port selection
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = '0;
    case (cmd_i.cmd)
      bfha_pkg::CMD_CLR: begin
        we    = 1'b1;
        waddr = {{(30 - IW){1'b0}}, clr_q, 2'b00};
        wdata = init_w;
      end
      bfha_pkg::CMD_A_RD:     begin re = 1'b1; raddr = cur_q;  end
      bfha_pkg::CMD_X_RD:     begin re = 1'b1; raddr = best_q; end
      bfha_pkg::CMD_S_RD:     begin re = 1'b1; raddr = best_q; end
      bfha_pkg::CMD_FX_RD:    begin re = 1'b1; raddr = blk_q;  end
      bfha_pkg::CMD_FX_RN:    begin re = 1'b1; raddr = nx_q;   end
      bfha_pkg::CMD_F_RD:     begin re = 1'b1; raddr = pcur_q; end
      bfha_pkg::CMD_F_PRD:    begin re = 1'b1; raddr = pcur_q - 32'd4; end
      bfha_pkg::CMD_F_NRD:    begin re = 1'b1; raddr = nx_q;   end
      bfha_pkg::CMD_F_PRV_RD: begin re = 1'b1; raddr = prev_q; end
      bfha_pkg::CMD_F_BRD:    begin re = 1'b1; raddr = blk_q;  end
      bfha_pkg::CMD_X_WR: begin
        we    = 1'b1;
        waddr = best_q;
        wdata = rd_val | bfha_pkg::A_FLAG;
      end
      bfha_pkg::CMD_S_W1: begin
        we    = 1'b1;
        waddr = best_q + need_q;
        wdata = (bs_q - need_q) | bfha_pkg::P_FLAG;
      end
      bfha_pkg::CMD_S_W2: begin
        we    = 1'b1;
        waddr = best_q + bs_q - 32'd4;
        wdata = bs_q - need_q;
      end
      bfha_pkg::CMD_S_W3: begin
        we    = 1'b1;
        waddr = best_q;
        wdata = ((rd_val & 32'd3) + need_q) | bfha_pkg::A_FLAG;
      end
      bfha_pkg::CMD_FX_WN: begin
        we    = 1'b1;
        waddr = nx_q;
        wdata = h_q[0] ? (rd_val | bfha_pkg::P_FLAG) : (rd_val & bfha_pkg::NOT_P);
      end
      bfha_pkg::CMD_F_PRV_WR: begin
        we    = 1'b1;
        waddr = prev_q;
        wdata = rd_val + freed_q;
      end
      bfha_pkg::CMD_F_BADD: begin
        we    = 1'b1;
        waddr = blk_q;
        wdata = rd_val + nxs_q;
      end
      bfha_pkg::CMD_F_CLRA: begin
        we    = 1'b1;
        waddr = blk_q;
        wdata = rd_val & bfha_pkg::NOT_A;
      end
      bfha_pkg::CMD_F_FOOT: begin
        we    = 1'b1;
        waddr = blk_q + (h_q & bfha_pkg::SIZE_MASK) - 32'd4;
        wdata = h_q & bfha_pkg::SIZE_MASK;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // heap memory, out-of-range accesses dropped or read as zero
  always_ff @(posedge clk_i) begin
    if (we && (waddr[31:2] < 30'(WORDS))) mem_q[waddr[IW+1:2]] <= wdata;
    rdata_q <= mem_q[raddr[IW+1:2]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ok_q <= 1'b0;
    else         rd_ok_q <= re && (raddr[31:2] < 30'(WORDS));
  end

  // walk, merge and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= bfha_pkg::OP_ALLOC;
      poff_q     <= '0;
      used_q     <= '0;
      clr_q      <= '0;
      n_q        <= '0;
      need_q     <= '0;
      pcur_q     <= '0;
      cur_q      <= '0;
      best_q     <= '0;
      bs_q       <= '0;
      h_q        <= '0;
      freed_q    <= '0;
      prev_q     <= '0;
      nx_q       <= '0;
      nxs_q      <= '0;
      blk_q      <= '0;
      has_prev_q <= 1'b0;
      has_next_q <= 1'b0;
      st_q       <= bfha_pkg::ST_OK;
      off_q      <= '0;
    end else begin
      case (cmd_i.cmd)
        bfha_pkg::CMD_CLR: clr_q <= clr_q + IW'(1);
        bfha_pkg::CMD_LOAD: begin
          op_q   <= opcode_i;
          poff_q <= payload_offset_i;
          need_q <= ({16'd0, request_bytes_i} + 32'd11) & 32'hFFFF_FFF8;
          pcur_q <= {16'd0, payload_offset_i} - 32'd4;
          cur_q  <= bfha_pkg::FIRST;
          n_q    <= '0;
          best_q <= '0;
          bs_q   <= '0;
        end
        bfha_pkg::CMD_A_EV: begin
          if (!rd_val[0]) begin
            if (size_rd == need_q) begin
              best_q <= cur_q;
              bs_q   <= size_rd;
            end else if ((size_rd >= need_q + bfha_pkg::MIN_SPLIT) &&
                         ((best_q == '0) || (size_rd < bs_q))) begin
              best_q <= cur_q;
              bs_q   <= size_rd;
            end
          end
          cur_q <= cur_q + size_rd;
          n_q   <= n_q + NW'(1);
        end
        bfha_pkg::CMD_X_WR: blk_q <= best_q;
        bfha_pkg::CMD_A_OK: begin
          used_q <= used_q + need_q[15:0];
          off_q  <= best_q[15:0] + 16'd4;
          st_q   <= bfha_pkg::ST_OK;
        end
        bfha_pkg::CMD_FX_EV: begin
          h_q  <= rd_val;
          nx_q <= blk_q + size_rd;
        end
        bfha_pkg::CMD_F_H: begin
          h_q        <= rd_val;
          freed_q    <= size_rd;
          nx_q       <= pcur_q + size_rd;
          blk_q      <= pcur_q;
          has_prev_q <= 1'b0;
          has_next_q <= 1'b0;
        end
        bfha_pkg::CMD_F_PV: begin
          if ((rd_val <= pcur_q) && (f_diff >= bfha_pkg::FIRST)) begin
            prev_q     <= f_diff;
            has_prev_q <= 1'b1;
          end
        end
        bfha_pkg::CMD_F_NV:     has_next_q <= !rd_val[0];
        bfha_pkg::CMD_F_PRV_WR: blk_q <= prev_q;
        bfha_pkg::CMD_F_NS:     nxs_q <= size_rd;
        bfha_pkg::CMD_F_CLRA:   h_q <= rd_val & bfha_pkg::NOT_A;
        bfha_pkg::CMD_F_OK: begin
          used_q <= ({16'd0, used_q} >= freed_q) ? used_q - freed_q[15:0] : '0;
          off_q  <= '0;
          st_q   <= bfha_pkg::ST_OK;
        end
        bfha_pkg::CMD_FIN: begin
          off_q <= '0;
          st_q  <= cmd_i.code;
        end
        default: begin
          off_q <= off_q;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts_o.clr_last  = (clr_q == IDX_LAST);
    sts_o.is_free   = (op_q == bfha_pkg::OP_FREE);
    sts_o.too_big   = (need_q > rem);
    sts_o.bad_off   = (poff_q == '0) || (poff_q[2:0] != 3'd0) || (poff_q < 16'd4) ||
                      ({16'd0, poff_q} >= LIMIT);
    sts_o.scan_go   = (cur_q < LIMIT) && (n_q <= NMAX);
    sts_o.scan_stop = (!rd_val[0] && (size_rd == need_q)) || (size_rd == '0);
    sts_o.best_zero = (best_q == '0);
    sts_o.exact     = (bs_q == need_q);
    sts_o.fx_go     = ((blk_q + size_rd) < LIMIT);
    sts_o.h_a       = rd_val[0];
    sts_o.h_p       = rd_val[1];
    sts_o.nx_in     = (nx_q < LIMIT);
    sts_o.has_prev  = has_prev_q;
    sts_o.has_next  = has_next_q;
    // a zero request rounds up to eight with no payload: flag it from the raw size
    sts_o.req_zero  = req_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_zero_q <= 1'b0;
    else if (cmd_i.cmd == bfha_pkg::CMD_LOAD) req_zero_q <= (request_bytes_i == '0);
  end

  assign status_o        = st_q;
  assign result_offset_o = off_q;

endmodule

// ===== sv/best_fit_heap_allocator.sv =====
// best_fit_heap_allocator: top level of the best-fit boundary-tag heap manager
// joins bfha_ctrl (sequencer) and bfha_dpath (heap memory and registers)
// depends on bfha_pkg, bfha_ctrl, bfha_dpath
//
// channel | dir | tdata                      | tuser
// s_axis  | in  | [15:0] request_bytes,      | [0] opcode
//         |     | [31:16] payload_offset     |
// m_axis  | out | [15:0] result_offset       | [2:0] status
//
// one request at a time; allocate visits the blocks in turn on the
// single memory read port, then splits the best block or takes an exact fit;
// free does all of its memory reads and writes in turn
// after reset a clearing pass writes every word of the initial heap
// with s_axis_tready_o low; the result stays on m_axis until taken
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] request_bytes, [31:16] payload_offset
  input  logic [0:0]  s_axis_tuser_i,  // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] result_offset
  output logic [2:0]  m_axis_tuser_o   // [2:0] status
);

  bfha_pkg::ctl_cmd_t cmd;
  bfha_pkg::dp_sts_t  sts;

  bfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfha_dpath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (s_axis_tuser_i[0]),
    .request_bytes_i  (s_axis_tdata_i[15:0]),
    .payload_offset_i (s_axis_tdata_i[31:16]),
    .sts_o            (sts),
    .status_o         (m_axis_tuser_o),
    .result_offset_o  (m_axis_tdata_o)
  );

endmodule

// ===== sv/bfha_checker.sv =====
// bfha_checker: port-level checks for best_fit_heap_allocator
// watches the stream handshakes and the result beat's offset and status; bound to the top level below
// depends on bfha_pkg
module bfha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while result pending");

  // an OK result gives an aligned offset, an error result gives zero
  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tuser_o == bfha_pkg::ST_OK) && (m_axis_tdata_o[2:0] == 3'd0)) ||
      ((m_axis_tuser_o != bfha_pkg::ST_OK) && (m_axis_tdata_o == 16'd0)))
    else $error("result offset inconsistent with status");

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= bfha_pkg::ST_ALR_FREE))
    else $error("status code out of range");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
